### design/rpd_pkg.sv
// Shared widths, constants and helper functions of the pitch drift generator.
package rpd_pkg;

  localparam int CFB     = 16;             // fraction bits of the cents values
  localparam int DRIFT_W = CFB + 9;        // signed drift, goal and clamp limit
  localparam int DIST_W  = CFB + 10;       // signed goal minus drift
  localparam int TICK_W  = 18;             // tick length in 2.16 seconds
  localparam int TIME_W  = 20;             // remaining time in 4.16 seconds
  localparam int OUT_W   = 26;
  localparam int DVD_W   = DIST_W + TICK_W;
  localparam int DVS_W   = (DIST_W > TIME_W) ? DIST_W : TIME_W;
  localparam int DCNT_W  = $clog2(DVD_W);
  localparam int MCNT_W  = $clog2(TICK_W);

  localparam logic [31:0] SEED_XOR   = 32'h6D2B79F5;
  localparam logic [31:0] SEED_MUL   = 32'h9E3779B9;
  localparam logic [31:0] SEED_RESET = 32'hF31C004C;
  localparam logic [7:0]  TUNE_BIAS  = 8'h80;
  localparam int TICK_NUM   = 163840;      // 2.5 seconds in 16.16
  localparam int TIME_BASE  = 6 * 65536;
  localparam int TIME_RANGE = 8 * 65536 + 1;

  localparam logic [1:0] FN_TICK    = 2'd0;
  localparam logic [1:0] FN_TUNE    = 2'd1;
  localparam logic [1:0] FN_DEPTH   = 2'd2;
  localparam logic [1:0] FN_RESTART = 2'd3;

  function automatic logic [31:0] xorshift(input logic [31:0] w);
    logic [31:0] x;
    x = w ^ (w << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [31:0] seed_for(input logic [7:0] voice);
    logic [8:0]  v1;
    logic [31:0] s;
    v1 = {1'b0, voice} + 9'd1;
    s  = SEED_XOR ^ 32'({23'd0, v1} * SEED_MUL);
    return (s == 32'd0) ? 32'd1 : s;
  endfunction

endpackage

### design/random_pitch_drift_generator.sv
// Top level: event sequencer, voice state and output register of the drift generator.
//
//   channel | signals                           | beat taken when
//   --------+-----------------------------------+---------------------------
//   input   | func, bpm, value                  | in_valid && in_ready
//   output  | cents_total, changed              | out_valid && out_ready
//   config  | cfg_we, cfg_wdata (voice_index)   | cfg_we
//
// Tune and restart events go straight to the output state. A target draw costs two
// serial divisions, plus setup; a tick costs one division for its length, then a serial
// multiply and one more division, with a draw before them or in their place when due.
// Reset is synchronous and needs no clearing pass. One event is in work at a time;
// a finished result waits in the output register while the next beat is taken.
module random_pitch_drift_generator import rpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [9:0]              bpm,
  input  logic [7:0]              value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] cents_total,
  output logic                    changed,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TDIV  = 4'd1;
  localparam logic [3:0] S_TWAIT = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_MWAIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_D1    = 4'd7;
  localparam logic [3:0] S_D1S   = 4'd8;
  localparam logic [3:0] S_D1W   = 4'd9;
  localparam logic [3:0] S_D2S   = 4'd10;
  localparam logic [3:0] S_D2W   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]                state;
  logic                      ret_check;
  logic [1:0]                fn;
  logic [9:0]                bpm_r;
  logic [7:0]                voice;
  logic [31:0]               rng;
  logic signed [7:0]         tune;
  logic [7:0]                depth;
  logic signed [DRIFT_W-1:0] drift;
  logic signed [DRIFT_W-1:0] goal;
  logic signed [DRIFT_W-1:0] drift_start;
  logic [TIME_W-1:0]         time_r;
  logic [TICK_W-1:0]         tick;
  logic                      neg;

  logic                      div_start;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;
  logic [DVS_W-1:0]          div_r;
  logic                      mul_start;
  logic                      mul_done;
  logic [DVD_W-1:0]          mul_p;

  logic signed [DIST_W-1:0]  drift_gap;
  logic [DIST_W-1:0]         mag;
  logic signed [DRIFT_W-1:0] lim;
  logic signed [DIST_W-1:0]  goal_new;
  logic [DRIFT_W-1:0]        step;
  logic                      tick_ends;

  assign drift_gap = DIST_W'(goal) - DIST_W'(drift);
  assign mag  = drift_gap[DIST_W-1] ? DIST_W'(-drift_gap) : DIST_W'(drift_gap);
  assign lim  = $signed({1'b0, value, {CFB{1'b0}}});
  assign goal_new = $signed({1'b0, div_r[CFB+8:0]}) - $signed({2'b00, depth, {CFB{1'b0}}});
  assign step = div_q[DRIFT_W-1:0];
  assign tick_ends = {{(TIME_W-TICK_W){1'b0}}, tick} >= time_r;

  assign in_ready  = state == S_IDLE;
  assign mul_start = state == S_CHECK && !tick_ends;
  assign div_start = state == S_TDIV || state == S_DIV || state == S_D1S || state == S_D2S;

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    case (state)
      S_TDIV: begin
        div_dvd = DVD_W'(TICK_NUM);
        div_dvs = (bpm_r == 10'd0) ? DVS_W'(1) : DVS_W'(bpm_r);
      end
      S_DIV: begin
        div_dvd = mul_p;
        div_dvs = DVS_W'(time_r);
      end
      S_D1S: begin
        div_dvd = DVD_W'(rng);
        div_dvs = DVS_W'({depth, {CFB{1'b0}}, 1'b1});
      end
      S_D2S: begin
        div_dvd = DVD_W'(rng);
        div_dvs = DVS_W'(TIME_RANGE);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  rpd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  rpd_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mag),
    .b       (tick),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_check <= 1'b0;
      voice     <= '0;
      rng       <= SEED_RESET;
      tune      <= '0;
      depth     <= '0;
      drift     <= '0;
      goal      <= '0;
      time_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        voice <= cfg_wdata;
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            fn          <= func;
            bpm_r       <= bpm;
            drift_start <= drift;
            case (func)
              FN_TUNE: begin
                tune  <= $signed(value - TUNE_BIAS);
                state <= S_OUT;
              end
              FN_RESTART: begin
                tune   <= '0;
                depth  <= '0;
                drift  <= '0;
                goal   <= '0;
                time_r <= '0;
                rng    <= seed_for(voice);
                state  <= S_OUT;
              end
              FN_DEPTH: begin
                depth <= value;
                if (value == 8'd0) begin
                  drift  <= '0;
                  goal   <= '0;
                  time_r <= '0;
                  state  <= S_OUT;
                end else begin
                  if (drift > lim) begin
                    drift <= lim;
                  end else if (drift < -lim) begin
                    drift <= -lim;
                  end
                  ret_check <= 1'b0;
                  state     <= S_D1;
                end
              end
              default: begin
                state <= (depth == 8'd0) ? S_OUT : S_TDIV;
              end
            endcase
          end
        end
        S_TDIV:  state <= S_TWAIT;
        S_TWAIT: begin
          if (div_done) begin
            tick <= div_q[TICK_W-1:0];
            if (time_r == '0) begin
              ret_check <= 1'b1;
              state     <= S_D1;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (tick_ends) begin
            drift     <= goal;
            ret_check <= 1'b0;
            state     <= S_D1;
          end else begin
            neg   <= drift_gap[DIST_W-1];
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            drift  <= neg ? drift - $signed(step) : drift + $signed(step);
            time_r <= time_r - TIME_W'(tick);
            state  <= S_OUT;
          end
        end
        S_D1: begin
          rng   <= xorshift(rng);
          state <= S_D1S;
        end
        S_D1S:   state <= S_D1W;
        S_D1W: begin
          if (div_done) begin
            goal  <= goal_new[DRIFT_W-1:0];
            rng   <= xorshift(rng);
            state <= S_D2S;
          end
        end
        S_D2S:   state <= S_D2W;
        S_D2W: begin
          if (div_done) begin
            time_r <= TIME_W'(TIME_BASE) + div_r[TIME_W-1:0];
            state  <= ret_check ? S_CHECK : S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The result is sampled from the state as the event leaves the sequencer.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      cents_total <= OUT_W'($signed({tune, {CFB{1'b0}}})) + OUT_W'(drift);
      changed     <= (fn == FN_TICK) && (drift != drift_start);
    end
  end

endmodule

### design/rpd_divider.sv
// Bit-serial restoring divider giving quotient and remainder, one bit a cycle.
module rpd_divider import rpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == DCNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      count <= '0;
    end else if (busy) begin
      rem   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo   <= {quo[DVD_W-2:0], fits};
      count <= count + DCNT_W'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### design/rpd_multiplier.sv
// Shift-and-add multiplier taking one bit of the tick length each cycle.
module rpd_multiplier import rpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIST_W-1:0] a,
  input  logic [TICK_W-1:0] b,
  output logic              done,
  output logic [DVD_W-1:0]  product
);

  logic              busy;
  logic [MCNT_W-1:0] count;
  logic [DVD_W-1:0]  p;
  logic [DIST_W-1:0] mcand;
  logic [DIST_W:0]   sum;

  assign sum = {1'b0, p[DVD_W-1:TICK_W]} + (p[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == MCNT_W'(TICK_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p     <= {{DIST_W{1'b0}}, b};
      mcand <= a;
      count <= '0;
    end else if (busy) begin
      p     <= {sum, p[TICK_W-1:1]};
      count <= count + MCNT_W'(1);
    end
  end

  assign product = p;

endmodule
